### rtl/lik_pkg.sv
// Package for the leg inverse kinematics block.
// Holds types, fixed-point constants, register codes and the CORDIC arctangent table.
// Used by lik_ctrl, lik_dp and leg_inverse_kinematics.
package lik_pkg;

  localparam int CNT_W     = 5;
  localparam int ACC_W     = 58;
  localparam int CRD_W     = 34;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0] SQ_LAST  = 5'd28;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd27;

  localparam logic signed [19:0]      PI_Q14      = 20'sd51472;
  localparam logic signed [19:0]      HALF_PI_Q14 = 20'sd25736;
  localparam logic signed [CRD_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic [ACC_W-1:0]        ONE_Q56     = 58'h100000000000000;

  localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTMIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTMAX = 3'd4;

  localparam logic [15:0] RST_UPPER  = 16'd3277;
  localparam logic [15:0] RST_LOWER  = 16'd6554;
  localparam logic [15:0] RST_EXTMIN = 16'd3277;
  localparam logic [15:0] RST_EXTMAX = 16'd7864;
  localparam logic [15:0] RST_EXT    = 16'd3277;

  typedef enum logic [1:0] {
    OP_SET_XY  = 2'd0,
    OP_SET_EXT = 2'd1,
    OP_SET_ANG = 2'd2,
    OP_UNUSED  = 2'd3
  } lik_op_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_XSQ, CMD_YSQ, CMD_XYSUM, CMD_SQ_INIT, CMD_SQ_STEP,
    CMD_EXT_XY, CMD_ANG_ZERO, CMD_CX_INIT, CMD_CR_STEP, CMD_ANG_XY, CMD_EXT_SET,
    CMD_ANG_SET, CMD_L1SQ, CMD_L2SQ, CMD_ESQ, CMD_L12, CMD_DEN, CMD_DELTA_FIX,
    CMD_DIV_INIT, CMD_DIV_STEP, CMD_QSQ, CMD_QSUB, CMD_CA_INIT, CMD_DELTA_ACOS,
    CMD_TARGETS, CMD_PUBLISH
  } lik_cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_XSQ, S_YSQ, S_XYSUM, S_SQ_INIT, S_SQ_STEP, S_EXT_XY,
    S_ANG_ZERO, S_CX_INIT, S_CR_STEP, S_ANG_XY, S_EXT_SET, S_ANG_SET, S_L1SQ,
    S_L2SQ, S_ESQ, S_L12, S_DEN, S_CHECK, S_DELTA_FIX, S_DIV_INIT, S_DIV_STEP,
    S_QSQ, S_QSUB, S_CA_INIT, S_DELTA_ACOS, S_TARGETS, S_FINISH
  } lik_state_e;

  typedef struct packed {
    lik_cmd_e         op;
    logic [CNT_W-1:0] idx;
    logic             changed;
  } lik_cmd_t;

  typedef struct packed {
    lik_op_e op;
    logic    apply;
    logic    y_zero;
    logic    fixed;
  } lik_stat_t;

  // atan(2^-i) in Q2.29
  function automatic logic [28:0] atan_q29(input logic [CNT_W-1:0] i);
    logic [28:0] v;
    case (i)
      5'd0:  v = 29'd421657428;
      5'd1:  v = 29'd248918915;
      5'd2:  v = 29'd131521918;
      5'd3:  v = 29'd66762579;
      5'd4:  v = 29'd33510843;
      5'd5:  v = 29'd16771758;
      5'd6:  v = 29'd8387925;
      5'd7:  v = 29'd4194219;
      5'd8:  v = 29'd2097141;
      5'd9:  v = 29'd1048575;
      5'd10: v = 29'd524288;
      5'd11: v = 29'd262144;
      5'd12: v = 29'd131072;
      5'd13: v = 29'd65536;
      5'd14: v = 29'd32768;
      5'd15: v = 29'd16384;
      5'd16: v = 29'd8192;
      5'd17: v = 29'd4096;
      5'd18: v = 29'd2048;
      5'd19: v = 29'd1024;
      5'd20: v = 29'd512;
      5'd21: v = 29'd256;
      5'd22: v = 29'd128;
      5'd23: v = 29'd64;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/lik_ctrl.sv
// Sequencer for the leg inverse kinematics block.
// Depends on lik_pkg; drives lik_dp through a command struct and reads its status.
module lik_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  lik_pkg::lik_stat_t stat_i,
  output lik_pkg::lik_cmd_t  cmd_o
);
  import lik_pkg::*;

  localparam logic [CNT_W-1:0] CR_LAST = CNT_W'(CORDIC_STEPS - 1);

  lik_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acos_q, acos_d;
  logic             chg_q, chg_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 1'b1;
    acos_d      = acos_q;
    chg_d       = chg_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        chg_d  = stat_i.apply;
        acos_d = 1'b0;
        if (!stat_i.apply) begin
          state_d = S_FINISH;
        end else begin
          case (stat_i.op)
            OP_SET_XY:  state_d = S_XSQ;
            OP_SET_EXT: state_d = S_EXT_SET;
            OP_SET_ANG: state_d = S_ANG_SET;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_XSQ:   state_d = S_YSQ;
      S_YSQ:   state_d = S_XYSUM;
      S_XYSUM: state_d = S_SQ_INIT;
      S_SQ_INIT: begin
        cnt_d   = '0;
        state_d = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        if (cnt_q == SQ_LAST) state_d = acos_q ? S_CA_INIT : S_EXT_XY;
      end
      S_EXT_XY: state_d = stat_i.y_zero ? S_ANG_ZERO : S_CX_INIT;
      S_CX_INIT, S_CA_INIT: begin
        cnt_d   = '0;
        state_d = S_CR_STEP;
      end
      S_CR_STEP: begin
        if (cnt_q == CR_LAST) state_d = acos_q ? S_DELTA_ACOS : S_ANG_XY;
      end
      S_ANG_XY, S_ANG_ZERO, S_EXT_SET, S_ANG_SET: state_d = S_L1SQ;
      S_L1SQ: state_d = S_L2SQ;
      S_L2SQ: state_d = S_ESQ;
      S_ESQ:  state_d = S_L12;
      S_L12:  state_d = S_DEN;
      S_DEN:  state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.fixed) begin
          state_d = S_DELTA_FIX;
        end else begin
          acos_d  = 1'b1;
          state_d = S_DIV_INIT;
        end
      end
      S_DELTA_FIX: state_d = S_TARGETS;
      S_DIV_INIT: begin
        cnt_d   = '0;
        state_d = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (cnt_q == DIV_LAST) state_d = S_QSQ;
      end
      S_QSQ:        state_d = S_QSUB;
      S_QSUB:       state_d = S_SQ_INIT;
      S_DELTA_ACOS: state_d = S_TARGETS;
      S_TARGETS:    state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.idx     = cnt_q;
    cmd_o.changed = chg_q;
    in_stall_o    = (state_q != S_IDLE);
    out_valid_o   = out_valid_q;
    case (state_q)
      S_IDLE:       cmd_o.op = in_valid_i ? CMD_LOAD : CMD_NONE;
      S_XSQ:        cmd_o.op = CMD_XSQ;
      S_YSQ:        cmd_o.op = CMD_YSQ;
      S_XYSUM:      cmd_o.op = CMD_XYSUM;
      S_SQ_INIT:    cmd_o.op = CMD_SQ_INIT;
      S_SQ_STEP:    cmd_o.op = CMD_SQ_STEP;
      S_EXT_XY:     cmd_o.op = CMD_EXT_XY;
      S_ANG_ZERO:   cmd_o.op = CMD_ANG_ZERO;
      S_CX_INIT:    cmd_o.op = CMD_CX_INIT;
      S_CR_STEP:    cmd_o.op = CMD_CR_STEP;
      S_ANG_XY:     cmd_o.op = CMD_ANG_XY;
      S_EXT_SET:    cmd_o.op = CMD_EXT_SET;
      S_ANG_SET:    cmd_o.op = CMD_ANG_SET;
      S_L1SQ:       cmd_o.op = CMD_L1SQ;
      S_L2SQ:       cmd_o.op = CMD_L2SQ;
      S_ESQ:        cmd_o.op = CMD_ESQ;
      S_L12:        cmd_o.op = CMD_L12;
      S_DEN:        cmd_o.op = CMD_DEN;
      S_DELTA_FIX:  cmd_o.op = CMD_DELTA_FIX;
      S_DIV_INIT:   cmd_o.op = CMD_DIV_INIT;
      S_DIV_STEP:   cmd_o.op = CMD_DIV_STEP;
      S_QSQ:        cmd_o.op = CMD_QSQ;
      S_QSUB:       cmd_o.op = CMD_QSUB;
      S_CA_INIT:    cmd_o.op = CMD_CA_INIT;
      S_DELTA_ACOS: cmd_o.op = CMD_DELTA_ACOS;
      S_TARGETS:    cmd_o.op = CMD_TARGETS;
      S_FINISH:     cmd_o.op = out_free ? CMD_PUBLISH : CMD_NONE;
      default:      cmd_o.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      acos_q      <= 1'b0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acos_q      <= acos_d;
      chg_q       <= chg_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/lik_dp.sv
// Datapath for the leg inverse kinematics block: config, leg state, shared
// multiplier, square root, divider and CORDIC registers. Depends on lik_pkg.
module lik_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lik_pkg::lik_cmd_t                 cmd_i,
  output lik_pkg::lik_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [lik_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lik_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  logic [1:0]                        op_i,
  input  logic signed [16:0]                foot_x_i,
  input  logic signed [16:0]                foot_y_i,
  input  logic signed [16:0]                new_extension_i,
  input  logic signed [17:0]                new_angle_i,
  output logic signed [17:0]                motor_angle_a_o,
  output logic signed [17:0]                motor_angle_b_o,
  output logic signed [17:0]                leg_angle_now_o,
  output logic [15:0]                       leg_extension_now_o,
  output logic                              changed_o
);
  import lik_pkg::*;

  // configuration
  logic        mirror_q;
  logic [15:0] upper_q, lower_q, extmin_q, extmax_q;
  // leg state
  logic signed [17:0] angle_q, ta_q, tb_q;
  logic        [15:0] ext_q;
  logic signed [16:0] last_x_q, last_y_q;
  // command operands
  lik_op_e            op_q;
  logic signed [16:0] x_q, y_q, ne_q;
  logic signed [17:0] na_q;
  // arithmetic
  logic signed [29:0]       mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod_d, prod_q, acc_q, den_s;
  logic        [33:0]       den_q;
  logic        [ACC_W-1:0]  sq_rem_q, sq_r_q, sq_bit_q, sq_trial;
  logic        [29:0]       sq_root;
  logic        [33:0]       dv_rem_q, dv_init;
  logic                     dv_top;
  logic        [27:0]       dv_low_q;
  logic        [28:0]       dv_q_q;
  logic        [34:0]       dv_t;
  logic        [ACC_W-1:0]  acc_mag;
  logic                     neg_q;
  logic signed [CRD_W-1:0]  cx_q, cy_q, cz_q, cdx, cdy, ctab, ext_x, ext_y, cacos;
  logic signed [19:0]       delta_q, ang_zero;
  logic                     repeat_cmd;

  function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
    logic signed [17:0] r;
    if (v > 21'sd131071)       r = 18'sd131071;
    else if (v < -21'sd131072) r = -18'sd131072;
    else                       r = v[17:0];
    return r;
  endfunction

  function automatic logic signed [19:0] to_q14(input logic signed [CRD_W-1:0] a);
    logic [CRD_W-1:0] mag, rnd;
    logic [19:0]      r;
    mag = a[CRD_W-1] ? CRD_W'(-a) : CRD_W'(a);
    rnd = mag + CRD_W'(1 << 14);
    r   = {1'b0, rnd[33:15]};
    return a[CRD_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [17:0] mirrored(input logic signed [19:0] a, input logic m);
    logic signed [20:0] w;
    w = 21'(a);
    return m ? sat18(-w) : sat18(w);
  endfunction

  function automatic logic [15:0] clamp_ext(input logic signed [30:0] e,
                                            input logic [15:0] lo, input logic [15:0] hi);
    logic signed [30:0] v;
    v = e;
    if (v >= $signed({15'b0, hi})) v = $signed({15'b0, hi});
    if (v <= $signed({15'b0, lo})) v = $signed({15'b0, lo});
    return v[15:0];
  endfunction

  // status toward the sequencer
  always_comb begin
    case (op_q)
      OP_SET_XY:  repeat_cmd = (x_q == last_x_q) && (y_q == last_y_q);
      OP_SET_EXT: repeat_cmd = (ne_q == $signed({1'b0, ext_q}));
      OP_SET_ANG: repeat_cmd = (na_q == angle_q);
      default:    repeat_cmd = 1'b1;
    endcase
  end

  assign den_s         = $signed({24'b0, den_q});
  assign stat_o.op     = op_q;
  assign stat_o.apply  = !repeat_cmd;
  assign stat_o.y_zero = (y_q == '0);
  assign stat_o.fixed  = (den_q == '0) || (acc_q >= den_s) || (acc_q <= -den_s);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      CMD_XSQ:  begin mul_a = 30'(x_q);            mul_b = 30'(x_q); end
      CMD_YSQ:  begin mul_a = 30'(y_q);            mul_b = 30'(y_q); end
      CMD_L1SQ: begin mul_a = $signed({14'b0, upper_q}); mul_b = $signed({14'b0, upper_q}); end
      CMD_L2SQ: begin mul_a = $signed({14'b0, lower_q}); mul_b = $signed({14'b0, lower_q}); end
      CMD_ESQ:  begin mul_a = $signed({14'b0, ext_q});   mul_b = $signed({14'b0, ext_q}); end
      CMD_L12:  begin mul_a = $signed({14'b0, upper_q}); mul_b = $signed({14'b0, lower_q}); end
      CMD_QSQ:  begin mul_a = $signed({1'b0, dv_q_q});   mul_b = $signed({1'b0, dv_q_q}); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  assign sq_trial = sq_r_q + sq_bit_q;
  assign sq_root  = sq_r_q[29:0] + 30'(sq_rem_q > sq_r_q);
  assign dv_t     = {dv_rem_q, dv_low_q[27]};
  assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  // the quotient reaches 2^28 when |num| lies within den / 2^29 of den
  assign dv_init  = acc_mag[33:0] + 34'(den_q[33:29]);
  assign dv_top   = (dv_init >= den_q);
  assign cdx      = cy_q >>> cmd_i.idx;
  assign cdy      = cx_q >>> cmd_i.idx;
  assign ctab     = $signed({5'b0, atan_q29(cmd_i.idx)});
  assign ext_x    = CRD_W'(x_q) <<< 12;
  assign ext_y    = CRD_W'(y_q) <<< 12;
  assign cacos    = neg_q ? PI_Q29 - cz_q : cz_q;
  assign ang_zero = (x_q > 0) ? -HALF_PI_Q14 : ((x_q < 0) ? HALF_PI_Q14 : 20'sd0);

  // configuration and leg state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 1'b0;
      upper_q  <= RST_UPPER;
      lower_q  <= RST_LOWER;
      extmin_q <= RST_EXTMIN;
      extmax_q <= RST_EXTMAX;
      angle_q  <= '0;
      ext_q    <= RST_EXT;
      last_x_q <= '0;
      last_y_q <= '0;
      ta_q     <= '0;
      tb_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MIRROR: mirror_q <= cfg_data_i[0];
          REG_UPPER:  upper_q  <= cfg_data_i;
          REG_LOWER:  lower_q  <= cfg_data_i;
          REG_EXTMIN: extmin_q <= cfg_data_i;
          REG_EXTMAX: extmax_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        CMD_EXT_XY: begin
          ext_q    <= clamp_ext($signed({1'b0, sq_root}), extmin_q, extmax_q);
          last_x_q <= x_q;
          last_y_q <= y_q;
        end
        CMD_ANG_ZERO: angle_q <= mirrored(ang_zero, mirror_q);
        CMD_ANG_XY:   angle_q <= mirrored(to_q14(cz_q), mirror_q);
        CMD_EXT_SET:  ext_q   <= clamp_ext(31'(ne_q), extmin_q, extmax_q);
        CMD_ANG_SET:  angle_q <= mirrored(20'(na_q), mirror_q);
        CMD_TARGETS: begin
          ta_q <= sat18(21'(angle_q) - 21'(delta_q));
          tb_q <= sat18(21'(angle_q) + 21'(delta_q));
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      CMD_LOAD: begin
        op_q <= lik_op_e'(op_i);
        x_q  <= foot_x_i;
        y_q  <= foot_y_i;
        ne_q <= new_extension_i;
        na_q <= new_angle_i;
      end
      CMD_YSQ, CMD_L2SQ: acc_q <= prod_q;
      CMD_XYSUM, CMD_ESQ: acc_q <= acc_q + prod_q;
      CMD_L12:  acc_q <= acc_q - prod_q;
      CMD_DEN:  den_q <= {prod_q[32:0], 1'b0};
      CMD_QSUB: acc_q <= $signed(ONE_Q56) - prod_q;
      CMD_SQ_INIT: begin
        sq_rem_q <= acc_q;
        sq_r_q   <= '0;
        sq_bit_q <= ONE_Q56;
      end
      CMD_SQ_STEP: begin
        if (sq_rem_q >= sq_trial) begin
          sq_rem_q <= sq_rem_q - sq_trial;
          sq_r_q   <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q   <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      CMD_CX_INIT: begin
        // fold the sign of -y into both operands so x stays positive
        if (y_q > 0) begin
          cx_q <= ext_y;
          cy_q <= -ext_x;
        end else begin
          cx_q <= -ext_y;
          cy_q <= ext_x;
        end
        cz_q <= '0;
      end
      CMD_CA_INIT: begin
        cx_q <= $signed({5'b0, dv_q_q});
        cy_q <= $signed({4'b0, sq_root});
        cz_q <= '0;
      end
      CMD_CR_STEP: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cdx;
          cy_q <= cy_q - cdy;
          cz_q <= cz_q + ctab;
        end else begin
          cx_q <= cx_q - cdx;
          cy_q <= cy_q + cdy;
          cz_q <= cz_q - ctab;
        end
      end
      CMD_DELTA_FIX:  delta_q <= acc_q[ACC_W-1] ? PI_Q14 : 20'sd0;
      CMD_DELTA_ACOS: delta_q <= to_q14(cacos);
      CMD_DIV_INIT: begin
        neg_q    <= acc_q[ACC_W-1];
        dv_rem_q <= dv_top ? dv_init - den_q : dv_init;
        dv_low_q <= den_q[28:1];
        dv_q_q   <= {28'b0, dv_top};
      end
      CMD_DIV_STEP: begin
        if (dv_t >= {1'b0, den_q}) begin
          dv_rem_q <= 34'(dv_t - {1'b0, den_q});
          dv_q_q   <= {dv_q_q[27:0], 1'b1};
        end else begin
          dv_rem_q <= dv_t[33:0];
          dv_q_q   <= {dv_q_q[27:0], 1'b0};
        end
        dv_low_q <= dv_low_q << 1;
      end
      CMD_PUBLISH: begin
        motor_angle_a_o     <= ta_q;
        motor_angle_b_o     <= tb_q;
        leg_angle_now_o     <= angle_q;
        leg_extension_now_o <= ext_q;
        changed_o           <= cmd_i.changed;
      end
      default: ;
    endcase
  end

endmodule

### rtl/leg_inverse_kinematics.sv
// Top level of the two-link leg inverse kinematics block.
// Depends on lik_pkg, lik_ctrl (sequencer) and lik_dp (datapath).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command item: op_i selects
//   set foot xy, set extension or set angle, with the matching payload ports.
//   An item is taken on a rising edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) returns one result item per command:
//   both motor target angles, the stored leg angle and extension, and changed_o.
//   Configuration (cfg_valid_i / cfg_ready_o) writes mirror_leg, upper_link,
//   lower_link, ext_min and ext_max at indexes 0 to 4; ready is always high.
//   Write configuration only while the block is idle.
// Timing:
//   One item at a time. The 29-step square root, the 28-step divider and the
//   CORDIC iterations all run one step per cycle on shared registers.
// Reset and stall:
//   Reset loads the default link lengths and limits, a 0.05 m extension and zero
//   angles. A finished result waits in the output register while the receiver
//   stalls; a new item may be accepted meanwhile, and the block holds its own
//   next result until the output register is free.
module leg_inverse_kinematics #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic signed [16:0]            foot_x_i,
  input  logic signed [16:0]            foot_y_i,
  input  logic signed [16:0]            new_extension_i,
  input  logic signed [17:0]            new_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [17:0]            motor_angle_a_o,
  output logic signed [17:0]            motor_angle_b_o,
  output logic signed [17:0]            leg_angle_now_o,
  output logic [15:0]                   leg_extension_now_o,
  output logic                          changed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lik_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lik_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import lik_pkg::*;

  lik_cmd_t  cmd;
  lik_stat_t stat;

  // registers accept a write on any cycle
  assign cfg_ready_o = 1'b1;

  lik_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lik_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .op_i                (op_i),
    .foot_x_i            (foot_x_i),
    .foot_y_i            (foot_y_i),
    .new_extension_i     (new_extension_i),
    .new_angle_i         (new_angle_i),
    .motor_angle_a_o     (motor_angle_a_o),
    .motor_angle_b_o     (motor_angle_b_o),
    .leg_angle_now_o     (leg_angle_now_o),
    .leg_extension_now_o (leg_extension_now_o),
    .changed_o           (changed_o)
  );

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after accepting an item");

  // a new result only appears at the end of work on an item
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised without an item in progress");

endmodule

### tb/sv/lik_checker.sv
// Scoreboard for the leg inverse kinematics block: predicts every result from the
// accepted commands and register writes, then compares each delivered result.
// Depends on lik_pkg for the operation and register codes.
module lik_checker
  import lik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           op_i,
  input  logic signed [16:0]   foot_x_i,
  input  logic signed [16:0]   foot_y_i,
  input  logic signed [16:0]   new_extension_i,
  input  logic signed [17:0]   new_angle_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [17:0]   motor_angle_a_i,
  input  logic signed [17:0]   motor_angle_b_i,
  input  logic signed [17:0]   leg_angle_now_i,
  input  logic [15:0]          leg_extension_now_i,
  input  logic                 changed_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   changed_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [17:0] angle_a;
    logic signed [17:0] angle_b;
    logic signed [17:0] leg_angle;
    logic [15:0]        leg_ext;
    logic               changed;
  } leg_result_t;

  localparam longint ATAN_TAB [24] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096,
    2048, 1024, 512, 256, 128, 64
  };

  leg_result_t expected_q[$];

  // register copy
  logic   mirror;
  longint link1, link2, ext_lo, ext_hi;
  // leg state copy
  longint leg_ang, leg_ext, last_x, last_y, tgt_a, tgt_b;

  function automatic longint unsigned sqrt_nearest(longint unsigned s);
    longint unsigned rem, r, b;
    rem = s;
    r = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // vectoring rotation, angle in Q2.29
  function automatic longint atan_vector(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_to_q14(longint a);
    longint unsigned m;
    longint r;
    m = (a < 0) ? -a : a;
    r = longint'((m + (64'd1 << 14)) >> 15);
    return (a < 0) ? -r : r;
  endfunction

  function automatic longint sat_angle(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint clamp_extension(longint e);
    if (e >= ext_hi) e = ext_hi;
    if (e <= ext_lo) e = ext_lo;
    return e;
  endfunction

  function automatic longint apply_mirror(longint a);
    return mirror ? sat_angle(-a) : sat_angle(a);
  endfunction

  task automatic solve_motor_targets();
    longint num, den, delta, a;
    longint unsigned m, q, s;
    num = link1 * link1 + link2 * link2 - leg_ext * leg_ext;
    den = 2 * link1 * link2;
    if (den == 0) begin
      delta = (num >= 0) ? 0 : PI_Q14;
    end else if (num >= den) begin
      delta = 0;
    end else if (num <= -den) begin
      delta = PI_Q14;
    end else begin
      m = (num < 0) ? -num : num;
      q = ((m << 28) + longint'(den) / 2) / longint'(den);
      s = sqrt_nearest((64'd1 << 56) - q * q);
      a = atan_vector(longint'(q), longint'(s));
      if (num < 0) a = longint'(PI_Q29) - a;
      delta = round_to_q14(a);
    end
    tgt_a = sat_angle(leg_ang - delta);
    tgt_b = sat_angle(leg_ang + delta);
  endtask

  task automatic predict_command(output leg_result_t res);
    longint x, y, ne, na, num, den, ang;
    logic chg;
    x = foot_x_i;
    y = foot_y_i;
    ne = new_extension_i;
    na = new_angle_i;
    chg = 1'b0;
    if (op_i == OP_SET_XY && !(x == last_x && y == last_y)) begin
      last_x = x;
      last_y = y;
      leg_ext = clamp_extension(longint'(sqrt_nearest(x * x + y * y)));
      num = x;
      den = -y;
      if (den == 0) begin
        ang = (x > 0) ? -HALF_PI_Q14 : ((x < 0) ? HALF_PI_Q14 : 0);
      end else begin
        if (den < 0) begin
          den = -den; num = -num;
        end
        ang = round_to_q14(atan_vector(den * 4096, num * 4096));
      end
      leg_ang = apply_mirror(ang);
      chg = 1'b1;
    end else if (op_i == OP_SET_EXT && ne != leg_ext) begin
      leg_ext = clamp_extension(ne);
      chg = 1'b1;
    end else if (op_i == OP_SET_ANG && na != leg_ang) begin
      leg_ang = apply_mirror(na);
      chg = 1'b1;
    end
    if (chg) solve_motor_targets();
    res.angle_a   = tgt_a[17:0];
    res.angle_b   = tgt_b[17:0];
    res.leg_angle = leg_ang[17:0];
    res.leg_ext   = leg_ext[15:0];
    res.changed   = chg;
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    leg_result_t exp_res, new_res;
    if (!rst_ni) begin
      mirror = 1'b0;
      link1 = RST_UPPER; link2 = RST_LOWER;
      ext_lo = RST_EXTMIN; ext_hi = RST_EXTMAX;
      leg_ang = 0; leg_ext = RST_EXT;
      last_x = 0; last_y = 0; tgt_a = 0; tgt_b = 0;
      expected_q.delete();
      fail_count_o <= 0;
      checked_o <= 0;
      changed_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MIRROR: mirror = cfg_data_i[0];
          REG_UPPER:  link1 = cfg_data_i;
          REG_LOWER:  link2 = cfg_data_i;
          REG_EXTMIN: ext_lo = cfg_data_i;
          REG_EXTMAX: ext_hi = cfg_data_i;
          default: ;
        endcase
      end
      // retire the oldest expectation before queuing a new one
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no command outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_res = expected_q.pop_front();
          checked_o <= checked_o + 1;
          if (motor_angle_a_i !== exp_res.angle_a) begin
            $error("motor_angle_a: expected %0d, got %0d", exp_res.angle_a, motor_angle_a_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (motor_angle_b_i !== exp_res.angle_b) begin
            $error("motor_angle_b: expected %0d, got %0d", exp_res.angle_b, motor_angle_b_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (leg_angle_now_i !== exp_res.leg_angle) begin
            $error("leg_angle_now: expected %0d, got %0d", exp_res.leg_angle, leg_angle_now_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (leg_extension_now_i !== exp_res.leg_ext) begin
            $error("leg_extension_now: expected %0d, got %0d", exp_res.leg_ext,
                   leg_extension_now_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (changed_i !== exp_res.changed) begin
            $error("changed: expected %0d, got %0d", exp_res.changed, changed_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_command(new_res);
        expected_q.push_back(new_res);
        if (new_res.changed) changed_count_o <= changed_count_o + 1;
      end
    end
  end

endmodule

### tb/sv/tb.sv
// Top of the leg inverse kinematics testbench: clock, reset, command stimulus,
// register phases, output stall patterns and the verdict.
// Depends on lik_pkg, lik_checker and the leg_inverse_kinematics RTL.
module tb;
  import lik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS = 16;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           op = OP_SET_XY;
  logic signed [16:0]   foot_x = '0;
  logic signed [16:0]   foot_y = '0;
  logic signed [16:0]   new_ext = '0;
  logic signed [17:0]   new_ang = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [17:0]   motor_a, motor_b, leg_angle;
  logic [15:0]          leg_ext;
  logic                 changed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIRROR;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count, pending, checked, changed_count;
  int burst_left = 0;
  // last values sent per field, reused to provoke repeats
  logic signed [16:0] prev_x = '0, prev_y = '0, prev_ext = 17'sd3277;
  logic signed [17:0] prev_ang = '0;
  int unsigned lo_bound = RST_EXTMIN, hi_bound = RST_EXTMAX;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  leg_inverse_kinematics #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .foot_x_i(foot_x), .foot_y_i(foot_y),
    .new_extension_i(new_ext), .new_angle_i(new_ang),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .motor_angle_a_o(motor_a), .motor_angle_b_o(motor_b),
    .leg_angle_now_o(leg_angle), .leg_extension_now_o(leg_ext), .changed_o(changed),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lik_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .foot_x_i(foot_x), .foot_y_i(foot_y),
    .new_extension_i(new_ext), .new_angle_i(new_ang),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .motor_angle_a_i(motor_a), .motor_angle_b_i(motor_b),
    .leg_angle_now_i(leg_angle), .leg_extension_now_i(leg_ext), .changed_i(changed),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .changed_count_o(changed_count)
  );

  // Receiver: switch between random stall patterns; once, hold off for a long
  // stretch so the block fills up and has to stall its input.
  always @(posedge clk_i) begin
    int unsigned cycle, mode, hold_left;
    cycle = cycle + 1;
    if (cycle == 30000) hold_left = 2500;
    if (cycle % 256 == 0) mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (mode)
        0: out_stall <= 1'b0;                             // no back-pressure
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 8);       // mostly stalled
        default: out_stall <= ((cycle / 7) % 3 == 0);     // regular gaps
      endcase
    end
  end

  // Offer one item and hold it until accepted. Called at a rising edge; returns
  // at the edge that took the item, leaving valid high for the next one.
  task automatic send_cmd(lik_op_e c, logic signed [16:0] x, logic signed [16:0] y,
                          logic signed [16:0] e, logic signed [17:0] a);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    op       <= c;
    foot_x   <= x;
    foot_y   <= y;
    new_ext  <= e;
    new_ang  <= a;
    if (c == OP_SET_XY) begin
      prev_x = x; prev_y = y;
    end
    if (c == OP_SET_EXT) prev_ext = e;
    if (c == OP_SET_ANG) prev_ang = a;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    burst_left = burst_left - 1;
  endtask

  // Drain all outstanding results, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_EXTMIN) lo_bound = val;
    if (idx == REG_EXTMAX) hi_bound = val;
  endtask

  task automatic set_leg(logic mir, logic [15:0] l1, logic [15:0] l2,
                         logic [15:0] emin, logic [15:0] emax);
    write_reg(REG_MIRROR, {15'd0, mir});
    write_reg(REG_UPPER, l1);
    write_reg(REG_LOWER, l2);
    write_reg(REG_EXTMIN, emin);
    write_reg(REG_EXTMAX, emax);
  endtask

  // Random commands: plausible leg poses mixed with full-range noise, some
  // repeats of the last value and a few unused opcodes.
  task automatic send_random(int count);
    int unsigned pick, lo, hi;
    logic signed [16:0] x, y, e;
    logic signed [17:0] a;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      x = ($urandom_range(0, 1) == 0) ? 17'($urandom) : 17'($signed($urandom_range(0, 16000)) - 8000);
      y = ($urandom_range(0, 1) == 0) ? 17'($urandom) : 17'($signed($urandom_range(0, 16000)) - 12000);
      lo = (lo_bound < hi_bound) ? lo_bound : hi_bound;
      hi = (lo_bound < hi_bound) ? hi_bound : lo_bound;
      e = ($urandom_range(0, 2) == 0) ? 17'($urandom) : 17'($urandom_range(lo, hi));
      a = ($urandom_range(0, 1) == 0) ? 18'($urandom) : 18'($signed($urandom_range(0, 60000)) - 30000);
      if (pick < 6)
        send_cmd(OP_UNUSED, x, y, e, a);
      else if (pick < 12)
        send_cmd(OP_SET_XY, prev_x, prev_y, e, a);
      else if (pick < 18)
        send_cmd(OP_SET_EXT, x, y, prev_ext, a);
      else if (pick < 24)
        send_cmd(OP_SET_ANG, x, y, e, prev_ang);
      else if (pick < 60)
        send_cmd(OP_SET_XY, x, y, e, a);
      else if (pick < 80)
        send_cmd(OP_SET_EXT, x, y, e, a);
      else
        send_cmd(OP_SET_ANG, x, y, e, a);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: repeats of the reset state, the unused opcode, zero foot y,
    // field extremes and a plain pose.
    send_cmd(OP_SET_XY, 0, 0, 0, 0);
    send_cmd(OP_SET_EXT, 0, 0, 17'sd3277, 0);
    send_cmd(OP_SET_ANG, 0, 0, 0, 0);
    send_cmd(OP_UNUSED, -17'sd65536, 17'sd65535, -17'sd1, 18'sd131071);
    send_cmd(OP_SET_XY, 17'sd1000, 0, 0, 0);
    send_cmd(OP_SET_XY, -17'sd1000, 0, 0, 0);
    send_cmd(OP_SET_XY, 0, 0, 0, 0);
    send_cmd(OP_SET_XY, 17'sd65535, -17'sd65536, 0, 0);
    send_cmd(OP_SET_XY, -17'sd65536, 17'sd65535, 0, 0);
    send_cmd(OP_SET_XY, -17'sd65536, -17'sd65536, 0, 0);
    send_cmd(OP_SET_XY, 17'sd65535, 17'sd65535, 0, 0);
    send_cmd(OP_SET_XY, 17'sd3000, -17'sd5000, 0, 0);
    send_cmd(OP_SET_XY, 17'sd3000, -17'sd5000, 0, 0);
    send_cmd(OP_SET_EXT, 0, 0, -17'sd65536, 0);
    send_cmd(OP_SET_EXT, 0, 0, 17'sd65535, 0);
    send_cmd(OP_SET_EXT, 0, 0, 17'sd5000, 0);
    send_cmd(OP_SET_EXT, 0, 0, 17'sd5000, 0);
    send_cmd(OP_SET_ANG, 0, 0, 0, -18'sd131072);
    send_cmd(OP_SET_ANG, 0, 0, 0, 18'sd131071);
    send_cmd(OP_SET_ANG, 0, 0, 0, 18'sd131071);
    send_random(110);

    // Mirrored leg with inverted limits: the lower bound wins.
    set_leg(1'b1, 16'd3277, 16'd6554, 16'd9000, 16'd2000);
    send_cmd(OP_SET_ANG, 0, 0, 0, -18'sd131072);
    send_cmd(OP_SET_ANG, 0, 0, 0, 18'sd131071);
    send_random(90);

    // Zero-length upper link with the widest limits.
    set_leg(1'b0, 16'd0, 16'd6554, 16'd0, 16'hFFFF);
    send_random(60);

    // Every length at full scale.
    set_leg(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(60);

    set_leg(1'b1, 16'd20000, 16'd30000, 16'd0, 16'd50000);
    send_random(170);

    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Checked %0d results (%0d changed the targets) over five register settings,",
             checked, changed_count);
    $display("covering repeats, zero foot y, inverted limits, zero and full-scale links.");
    if (fail_count == 0 && pending == 0) begin
      $display("[leg_inverse_kinematics] OK");
    end else begin
      $display("[leg_inverse_kinematics] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("[leg_inverse_kinematics] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/lik_pkg.sv
rtl/lik_ctrl.sv
rtl/lik_dp.sv
rtl/leg_inverse_kinematics.sv
tb/sv/lik_checker.sv
tb/sv/tb.sv
